// ----- src/aes_pkg.sv -----
// Shared types and constants for the ARM-style execute stage.
package aes_pkg;

   localparam int unsigned WordWidth = 32;
   localparam int unsigned QueueDepth = 4;

   typedef enum logic [1:0] {
      KIND_MUL    = 2'd0,
      KIND_DATA   = 2'd1,
      KIND_MEM    = 2'd2,
      KIND_BRANCH = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      SH_LSL = 2'd0,
      SH_LSR = 2'd1,
      SH_ASR = 2'd2,
      SH_ROR = 2'd3
   } shift_type;

   typedef enum logic [3:0] {
      OP_AND = 4'd0, OP_EOR = 4'd1, OP_SUB = 4'd2, OP_RSB = 4'd3,
      OP_ADD = 4'd4, OP_ADC = 4'd5, OP_SBC = 4'd6, OP_RSC = 4'd7,
      OP_TST = 4'd8, OP_TEQ = 4'd9, OP_CMP = 4'd10, OP_CMN = 4'd11,
      OP_ORR = 4'd12, OP_MOV = 4'd13, OP_BIC = 4'd14, OP_MVN = 4'd15
   } opcode_type;

   // Classified request handed from the front part to the back part.
   typedef struct packed {
      kind_type    kind;
      logic [31:0] instruction;
      logic [31:0] operand_first;
      logic [31:0] accumulate_value;
      logic [31:0] multiplicand;
      logic [31:0] operand_two;
      logic        shift_carry;
      logic [3:0]  flags_in;
   } work_type;

   typedef struct packed {
      logic [31:0] alu_out;
      logic        write_back;
      logic [31:0] updated_base;
      logic        link_flag;
      logic [3:0]  flags_out;
   } result_type;

endpackage

// ----- src/aes_front.sv -----
// Front part: accepts requests and resolves the barrel shifter operand.
module aes_front import aes_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  logic [1:0]  kind,
   input  logic [31:0] instruction,
   input  logic [31:0] operand_first,
   input  logic [31:0] accumulate_value,
   input  logic [31:0] multiplicand,
   input  logic [31:0] second_source,
   input  logic [7:0]  shift_source_byte,
   input  logic [3:0]  flags_in,
   output logic        out_valid,
   input  logic        out_ready,
   output work_type    out_work
);

   logic     valid_ff, valid_in;
   work_type work_ff, work_in;

   logic [31:0] rm, op2, lsl_r, lsr_r, asr_r, ror_r, rot_imm;
   logic [8:0]  amount;
   logic [4:0]  amt5, rot;
   logic        cin, sc, sign, shift_c, lsl_c, lsr_c, asr_c, ror_c;
   logic [1:0]  sh;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_work  = work_ff;

   always_comb begin
      rm   = second_source;
      cin  = flags_in[1];
      sign = rm[31];
      sh   = instruction[6:5];
      // Immediate amount zero means 32 for LSR and ASR; ROR zero is RRX.
      if (instruction[4] && kind == KIND_DATA) begin
         amount = {1'b0, shift_source_byte};
      end else if (instruction[11:7] == 5'd0 &&
                   (sh == SH_LSR || sh == SH_ASR)) begin
         amount = 9'd32;
      end else begin
         amount = {4'd0, instruction[11:7]};
      end
      amt5  = amount[4:0];
      lsl_r = rm << amt5;
      // For a nonzero amount the last bit shifted out sits at 32 minus the amount.
      lsl_c = (amt5 == 5'd0) ? rm[0] : rm[5'd0 - amt5];
      lsr_r = rm >> amt5;
      lsr_c = rm[amt5 - 5'd1];
      asr_r = $signed(rm) >>> amt5;
      ror_r = (rm >> amt5) | (rm << (6'd32 - {1'b0, amt5}));
      ror_c = (amt5 == 5'd0) ? sign : rm[amt5 - 5'd1];
      asr_c = rm[amt5 - 5'd1];
      if (amount == 9'd0) begin
         op2 = rm; shift_c = cin;
         if (!(instruction[4] && kind == KIND_DATA) && sh == SH_ROR) begin
            op2 = {cin, rm[31:1]}; shift_c = rm[0];
         end
      end else begin
         unique case (shift_type'(sh))
            SH_LSL: begin
               if (amount < 9'd32) begin op2 = lsl_r; shift_c = lsl_c; end
               else begin op2 = '0; shift_c = (amount == 9'd32) ? rm[0] : 1'b0; end
            end
            SH_LSR: begin
               if (amount < 9'd32) begin op2 = lsr_r; shift_c = lsr_c; end
               else begin op2 = '0; shift_c = (amount == 9'd32) ? sign : 1'b0; end
            end
            SH_ASR: begin
               if (amount < 9'd32) begin op2 = asr_r; shift_c = asr_c; end
               else begin op2 = {32{sign}}; shift_c = sign; end
            end
            SH_ROR: begin
               op2 = (amt5 == 5'd0) ? rm : ror_r; shift_c = ror_c;
            end
         endcase
      end
      rot     = {instruction[11:8], 1'b0};
      rot_imm = ({24'd0, instruction[7:0]} >> rot) |
                ({24'd0, instruction[7:0]} << (6'd32 - {1'b0, rot}));
      sc = shift_c;
      if (kind == KIND_DATA && instruction[25]) begin
         op2 = (rot == 5'd0) ? {24'd0, instruction[7:0]} : rot_imm;
         sc  = (rot == 5'd0) ? cin : op2[31];
      end else if (kind == KIND_MEM && !instruction[25]) begin
         op2 = {20'd0, instruction[11:0]};
      end else if (kind == KIND_MUL) begin
         op2 = rm;
      end
      work_in                  = work_ff;
      work_in.kind             = kind_type'(kind);
      work_in.instruction      = instruction;
      work_in.operand_first    = operand_first;
      work_in.accumulate_value = accumulate_value;
      work_in.multiplicand     = multiplicand;
      work_in.operand_two      = op2;
      work_in.shift_carry      = sc;
      work_in.flags_in         = flags_in;
      valid_in = valid_ff;
      if (in_ready) valid_in = in_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_valid && in_ready) work_ff <= work_in;
   end

endmodule

// ----- src/aes_queue.sv -----
// Short first-in first-out queue of classified requests.
module aes_queue import aes_pkg::*; #(
   parameter int unsigned Depth = QueueDepth
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   output logic     full,
   input  work_type push_data,
   input  logic     pop,
   output logic     empty,
   output work_type pop_data
);

   localparam int unsigned AddrWidth = (Depth > 1) ? $clog2(Depth) : 1;

   work_type               slot_ff [Depth];
   logic [AddrWidth-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [AddrWidth:0]     count_ff, count_in;

   assign full     = count_ff == (AddrWidth+1)'(Depth);
   assign empty    = count_ff == '0;
   assign pop_data = slot_ff[rd_ff];

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push && !full) begin
         wr_in = (wr_ff == AddrWidth'(Depth - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop && !empty) begin
         rd_in = (rd_ff == AddrWidth'(Depth - 1)) ? '0 : rd_ff + 1'b1;
      end
      if ((push && !full) && !(pop && !empty)) count_in = count_ff + 1'b1;
      if (!(push && !full) && (pop && !empty)) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
      if (push && !full) slot_ff[wr_ff] <= push_data;
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= (AddrWidth+1)'(Depth))
      else $error("queue count beyond depth");
   assert property (@(posedge clock) disable iff (reset)
      (push && !full && !pop) |=> !empty)
      else $error("queue empty after a push");
   assert property (@(posedge clock) disable iff (reset)
      (empty && !push) |=> empty)
      else $error("queue filled without a push");

endmodule

// ----- src/aes_back.sv -----
// Back part: multiplier, ALU, address generation and branch offset.
module aes_back import aes_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  work_type   in_work,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_result
);

   logic       valid_ff, valid_in;
   result_type res_ff, res_in;

   logic [31:0] op1, op2, x, y, sum_r, lres, base, boff;
   logic [32:0] sum;
   logic        c, logic_op, sbit, cin;
   logic [3:0]  fl;

   assign in_ready   = !valid_ff || out_ready;
   assign out_valid  = valid_ff;
   assign out_result = res_ff;

   always_comb begin
      op1  = in_work.operand_first;
      op2  = in_work.operand_two;
      sbit = in_work.instruction[20];
      cin  = in_work.flags_in[1];
      fl   = in_work.flags_in;
      x = op1; y = op2; c = 1'b0; logic_op = 1'b0; lres = '0;
      res_in = '0;
      res_in.write_back = 1'b1;
      unique case (opcode_type'(in_work.instruction[24:21]))
         OP_AND, OP_TST: begin lres = op1 & op2; logic_op = 1'b1; end
         OP_EOR, OP_TEQ: begin lres = op1 ^ op2; logic_op = 1'b1; end
         OP_SUB, OP_CMP: begin y = ~op2; c = 1'b1; end
         OP_RSB: begin x = op2; y = ~op1; c = 1'b1; end
         OP_ADD, OP_CMN: begin c = 1'b0; end
         OP_ADC: begin c = cin; end
         OP_SBC: begin y = ~op2; c = cin; end
         OP_RSC: begin x = op2; y = ~op1; c = cin; end
         OP_ORR: begin lres = op1 | op2; logic_op = 1'b1; end
         OP_MOV: begin lres = op2; logic_op = 1'b1; end
         OP_BIC: begin lres = op1 & ~op2; logic_op = 1'b1; end
         OP_MVN: begin lres = ~op2; logic_op = 1'b1; end
      endcase
      sum   = {1'b0, x} + {1'b0, y} + {32'd0, c};
      sum_r = sum[31:0];
      base  = in_work.instruction[23] ? op1 + op2 : op1 - op2;
      boff  = {{6{in_work.instruction[23]}}, in_work.instruction[23:0], 2'b00} + 32'd4;
      unique case (in_work.kind)
         KIND_MUL: begin
            res_in.alu_out = in_work.multiplicand * op2 +
                             (in_work.instruction[21] ? in_work.accumulate_value : 32'd0);
            if (sbit) fl = {res_in.alu_out[31], res_in.alu_out == 32'd0, fl[1:0]};
         end
         KIND_DATA: begin
            if (in_work.instruction[24:23] == 2'b10) res_in.write_back = 1'b0;
            if (logic_op) begin
               res_in.alu_out = lres;
               if (sbit) fl = {lres[31], lres == 32'd0, in_work.shift_carry, fl[0]};
            end else begin
               res_in.alu_out = sum_r;
               if (sbit) fl = {sum_r[31], sum_r == 32'd0, sum[32],
                               ~(x[31] ^ y[31]) & (x[31] ^ sum_r[31])};
            end
         end
         KIND_MEM: begin
            res_in.write_back   = 1'b0;
            res_in.updated_base = base;
            res_in.alu_out      = in_work.instruction[24] ? base : op1;
         end
         KIND_BRANCH: begin
            res_in.write_back = 1'b0;
            res_in.alu_out    = boff;
            res_in.link_flag  = in_work.instruction[24];
         end
      endcase
      res_in.flags_out = fl;
      valid_in = valid_ff;
      if (in_ready) valid_in = in_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_valid && in_ready) res_ff <= res_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !out_ready) |=> valid_ff)
      else $error("result dropped while stalled");
   assert property (@(posedge clock) disable iff (reset)
      (valid_ff && res_ff.link_flag) |-> !res_ff.write_back)
      else $error("link set on a register write");
   assert property (@(posedge clock) disable iff (reset)
      (in_valid && in_ready) |=> valid_ff)
      else $error("accepted request lost");

endmodule

// ----- src/arm_execute_stage_top.sv -----
// Throughput: one request per cycle while pop stays high; front register, queue and back
// register each pass one request a cycle, and the queue absorbs stalls between the two parts.
// The multiplier and the ALU adder in the back register set the critical path.
// Synchronous active-high reset empties the registers and the queue; no clearing pass.
module arm_execute_stage_top import aes_pkg::*; #(
   parameter int unsigned QDepth = QueueDepth
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [1:0]  req_kind,
   input  logic [31:0] req_instruction,
   input  logic [31:0] req_operand_first,
   input  logic [31:0] req_accumulate_value,
   input  logic [31:0] req_multiplicand,
   input  logic [31:0] req_second_source,
   input  logic [7:0]  req_shift_source_byte,
   input  logic [3:0]  req_flags_in,
   output logic        empty,
   input  logic        pop,
   output logic [31:0] rsp_alu_out,
   output logic        rsp_write_back,
   output logic [31:0] rsp_updated_base,
   output logic        rsp_link_flag,
   output logic [3:0]  rsp_flags_out
);

   logic       front_valid, front_ready, q_full, q_empty, back_ready, back_valid;
   logic       in_ready;
   work_type   front_work, q_work;
   result_type result;

   assign full  = !in_ready;
   assign empty = !back_valid;
   assign front_ready = !q_full;

   aes_front u_front (
      .clock, .reset,
      .in_valid(push), .in_ready,
      .kind(req_kind), .instruction(req_instruction),
      .operand_first(req_operand_first), .accumulate_value(req_accumulate_value),
      .multiplicand(req_multiplicand), .second_source(req_second_source),
      .shift_source_byte(req_shift_source_byte), .flags_in(req_flags_in),
      .out_valid(front_valid), .out_ready(front_ready), .out_work(front_work)
   );

   aes_queue #(.Depth(QDepth)) u_queue (
      .clock, .reset,
      .push(front_valid), .full(q_full), .push_data(front_work),
      .pop(back_ready), .empty(q_empty), .pop_data(q_work)
   );

   aes_back u_back (
      .clock, .reset,
      .in_valid(!q_empty), .in_ready(back_ready), .in_work(q_work),
      .out_valid(back_valid), .out_ready(pop), .out_result(result)
   );

   assign rsp_alu_out      = result.alu_out;
   assign rsp_write_back   = result.write_back;
   assign rsp_updated_base = result.updated_base;
   assign rsp_link_flag    = result.link_flag;
   assign rsp_flags_out    = result.flags_out;

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for the ARM-style execute stage behind its request queue.
module tb_top;
   import aes_pkg::*;

   localparam int unsigned NumRandom = 593;
   localparam int unsigned WatchLimit = 4000;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] instruction;
      logic [31:0] operand_first;
      logic [31:0] accumulate_value;
      logic [31:0] multiplicand;
      logic [31:0] second_source;
      logic [7:0]  shift_source_byte;
      logic [3:0]  flags_in;
   } request_type;

   typedef struct {
      request_type req;
      logic        typed;
      result_type  res;
   } stimulus_row;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        pop = 1'b0;
   logic        full;
   logic        empty;
   request_type drive_req = '0;
   result_type  seen;

   result_type  expected_results[$];
   int          error_count = 0;
   int          sender_idle_pct = 0;
   int          receiver_stall_pct = 0;
   logic        hold_off = 1'b0;
   int          quiet_cycles = 0;
   logic        stimulus_done = 1'b0;

   arm_execute_stage_top dut (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_kind(drive_req.kind), .req_instruction(drive_req.instruction),
      .req_operand_first(drive_req.operand_first),
      .req_accumulate_value(drive_req.accumulate_value),
      .req_multiplicand(drive_req.multiplicand),
      .req_second_source(drive_req.second_source),
      .req_shift_source_byte(drive_req.shift_source_byte),
      .req_flags_in(drive_req.flags_in),
      .empty(empty), .pop(pop),
      .rsp_alu_out(seen.alu_out), .rsp_write_back(seen.write_back),
      .rsp_updated_base(seen.updated_base), .rsp_link_flag(seen.link_flag),
      .rsp_flags_out(seen.flags_out)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic [31:0] rotate_right(logic [31:0] v, int n);
      n = n % 32;
      return (n == 0) ? v : ((v >> n) | (v << (32 - n)));
   endfunction

   // Barrel shifter for a resolved amount; zero passes the value with the old carry.
   function automatic logic [31:0] barrel_shift(logic [31:0] v, shift_type sh, int amount,
                                                logic cin, output logic cout);
      logic [31:0] r;
      logic        sign;
      sign = v[31];
      cout = cin;
      if (amount == 0) return v;
      case (sh)
         SH_LSL: begin
            if (amount < 32) begin cout = v[32 - amount]; return v << amount; end
            cout = (amount == 32) ? v[0] : 1'b0;
            return '0;
         end
         SH_LSR: begin
            if (amount < 32) begin cout = v[amount - 1]; return v >> amount; end
            cout = (amount == 32) ? sign : 1'b0;
            return '0;
         end
         SH_ASR: begin
            if (amount < 32) begin
               cout = v[amount - 1];
               r = $signed(v) >>> amount;
               return r;
            end
            cout = sign;
            return {32{sign}};
         end
         default: begin
            if (amount % 32 == 0) begin cout = sign; return v; end
            cout = v[(amount % 32) - 1];
            return rotate_right(v, amount);
         end
      endcase
   endfunction

   function automatic logic [31:0] shift_by_field(logic [31:0] instr, logic [31:0] rm,
                                                  logic cin, output logic cout);
      shift_type sh;
      int        amount;
      sh = shift_type'(instr[6:5]);
      amount = int'(instr[11:7]);
      if (amount == 0) begin
         if (sh == SH_LSR || sh == SH_ASR) amount = 32;
         else if (sh == SH_ROR) begin
            cout = rm[0];
            return {cin, rm[31:1]};
         end
      end
      return barrel_shift(rm, sh, amount, cin, cout);
   endfunction

   function automatic logic [3:0] nz_flags(logic [31:0] r);
      return {r[31], r == 32'd0, 2'b00};
   endfunction

   function automatic result_type execute_instruction(request_type q);
      result_type  o;
      logic [31:0] op2, x, y;
      logic [32:0] sum;
      logic        sc, cin, cy, logical;
      opcode_type  op;
      o = '0;
      o.flags_out = q.flags_in;
      cin = q.flags_in[1];
      case (kind_type'(q.kind))
         KIND_MUL: begin
            o.alu_out = q.multiplicand * q.second_source
                        + (q.instruction[21] ? q.accumulate_value : 32'd0);
            o.write_back = 1'b1;
            if (q.instruction[20])
               o.flags_out = nz_flags(o.alu_out) | (q.flags_in & 4'b0011);
         end
         KIND_DATA: begin
            if (q.instruction[25]) begin
               op2 = rotate_right({24'd0, q.instruction[7:0]}, 2 * q.instruction[11:8]);
               sc = (q.instruction[11:8] == 4'd0) ? cin : op2[31];
            end else if (q.instruction[4])
               op2 = barrel_shift(q.second_source, shift_type'(q.instruction[6:5]),
                                  int'(q.shift_source_byte), cin, sc);
            else
               op2 = shift_by_field(q.instruction, q.second_source, cin, sc);
            op = opcode_type'(q.instruction[24:21]);
            o.write_back = !(op inside {OP_TST, OP_TEQ, OP_CMP, OP_CMN});
            logical = 1'b1;
            x = '0; y = '0; cy = 1'b0;
            case (op)
               OP_AND, OP_TST: o.alu_out = q.operand_first & op2;
               OP_EOR, OP_TEQ: o.alu_out = q.operand_first ^ op2;
               OP_ORR: o.alu_out = q.operand_first | op2;
               OP_MOV: o.alu_out = op2;
               OP_BIC: o.alu_out = q.operand_first & ~op2;
               OP_MVN: o.alu_out = ~op2;
               OP_SUB, OP_CMP: begin x = q.operand_first; y = ~op2; cy = 1'b1; end
               OP_RSB: begin x = op2; y = ~q.operand_first; cy = 1'b1; end
               OP_ADD, OP_CMN: begin x = q.operand_first; y = op2; end
               OP_ADC: begin x = q.operand_first; y = op2; cy = cin; end
               OP_SBC: begin x = q.operand_first; y = ~op2; cy = cin; end
               default: begin x = op2; y = ~q.operand_first; cy = cin; end
            endcase
            if (!(op inside {OP_AND, OP_TST, OP_EOR, OP_TEQ, OP_ORR, OP_MOV, OP_BIC,
                             OP_MVN})) logical = 1'b0;
            if (logical) begin
               if (q.instruction[20])
                  o.flags_out = nz_flags(o.alu_out) | {2'b00, sc, q.flags_in[0]};
            end else begin
               sum = {1'b0, x} + {1'b0, y} + {32'd0, cy};
               o.alu_out = sum[31:0];
               if (q.instruction[20])
                  o.flags_out = nz_flags(sum[31:0])
                     | {2'b00, sum[32], ~(x[31] ^ y[31]) & (x[31] ^ sum[31])};
            end
         end
         KIND_MEM: begin
            if (q.instruction[25]) op2 = shift_by_field(q.instruction, q.second_source, cin, sc);
            else op2 = {20'd0, q.instruction[11:0]};
            o.updated_base = q.instruction[23] ? q.operand_first + op2
                                               : q.operand_first - op2;
            o.alu_out = q.instruction[24] ? o.updated_base : q.operand_first;
         end
         default: begin
            o.alu_out = ({{8{q.instruction[23]}}, q.instruction[23:0]} << 2) + 32'd4;
            o.link_flag = q.instruction[24];
         end
      endcase
      return o;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch on %s: got %h, expected %h", what, got, want);
      error_count++;
   endtask

   function automatic request_type random_request();
      request_type q;
      q.kind = 2'($urandom_range(3, 0));
      q.instruction = $urandom();
      q.operand_first = $urandom();
      q.accumulate_value = $urandom();
      q.multiplicand = $urandom();
      q.second_source = $urandom();
      q.shift_source_byte = 8'($urandom());
      q.flags_in = 4'($urandom());
      // Bias towards edge operands and shift amounts around 32.
      case ($urandom_range(7, 0))
         0: q.operand_first = $urandom_range(1, 0) ? 32'hFFFF_FFFF : 32'h8000_0000;
         1: q.second_source = $urandom_range(1, 0) ? 32'd0 : 32'h7FFF_FFFF;
         2: q.shift_source_byte = $urandom_range(1, 0) ? 8'd32 : 8'($urandom_range(64, 0));
         3: q.instruction[11:7] = 5'd0;
         default: ;
      endcase
      return q;
   endfunction

   task automatic send_request(request_type q);
      while ($urandom_range(99, 0) < sender_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      drive_req <= q;
      push <= 1'b1;
      @(posedge clock);
      while (full) @(posedge clock);
      expected_results.push_back(execute_instruction(q));
   endtask

   function automatic request_type make_request(logic [1:0] k, logic [31:0] instr,
                                                logic [31:0] rn, logic [31:0] rm,
                                                logic [7:0] rs, logic [3:0] fl);
      request_type q;
      q = '{k, instr, rn, 32'h0000_0010, 32'h0000_0003, rm, rs, fl};
      return q;
   endfunction

   function automatic result_type typed_result(logic [31:0] a, logic wb, logic [31:0] b,
                                               logic lk, logic [3:0] fl);
      result_type r;
      r = '{a, wb, b, lk, fl};
      return r;
   endfunction

   // Receiver: pops at random, and holds off completely while hold_off is set.
   always @(posedge clock) begin
      if (reset) pop <= 1'b0;
      else pop <= !hold_off && ($urandom_range(99, 0) >= receiver_stall_pct);
   end

   always @(posedge clock) begin
      result_type want;
      if (!reset && pop && !empty) begin
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected result", seen.alu_out, 32'd0);
         end else begin
            want = expected_results.pop_front();
            if (seen.alu_out !== want.alu_out)
               report_mismatch("alu_out", seen.alu_out, want.alu_out);
            if (seen.write_back !== want.write_back)
               report_mismatch("write_back", 32'(seen.write_back), 32'(want.write_back));
            if (seen.updated_base !== want.updated_base)
               report_mismatch("updated_base", seen.updated_base, want.updated_base);
            if (seen.link_flag !== want.link_flag)
               report_mismatch("link_flag", 32'(seen.link_flag), 32'(want.link_flag));
            if (seen.flags_out !== want.flags_out)
               report_mismatch("flags_out", 32'(seen.flags_out), 32'(want.flags_out));
         end
      end
   end

   // Watchdog on cycles without any accepted request or result.
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) quiet_cycles <= 0;
      else if (!stimulus_done || expected_results.size() != 0) begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WatchLimit) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin
      stimulus_row rows[$];
      result_type  typed_want;
      int          phase;
      rows.push_back('{make_request(KIND_MUL, 32'h0030_0000, 0, 32'h0000_0005, 0, 4'b0011),
                       1'b1, typed_result(32'h1F, 1, 0, 0, 4'b0011)});
      rows.push_back('{make_request(KIND_BRANCH, 32'h0100_0000, 0, 0, 0, 4'b1010),
                       1'b1, typed_result(32'd4, 0, 0, 1, 4'b1010)});
      rows.push_back('{make_request(KIND_BRANCH, 32'h00FF_FFFF, 0, 0, 0, 4'b0000),
                       1'b1, typed_result(32'd0, 0, 0, 0, 4'b0000)});
      rows.push_back('{make_request(KIND_MEM, 32'h0180_0FFF, 32'h1000, 0, 0, 4'b0101),
                       1'b1, typed_result(32'h1FFF, 0, 32'h1FFF, 0, 4'b0101)});
      rows.push_back('{make_request(KIND_MEM, 32'h0000_0001, 32'h0, 0, 0, 4'b0),
                       1'b1, typed_result(32'h0, 0, 32'hFFFF_FFFF, 0, 4'b0)});
      // CMP of equal values: zero and carry set, nothing written.
      rows.push_back('{make_request(KIND_DATA, 32'h0150_0000, 32'h7, 32'h7, 0, 4'b0),
                       1'b1, typed_result(32'h0, 0, 0, 0, 4'b0110)});
      // ADDS overflowing into the sign bit.
      rows.push_back('{make_request(KIND_DATA, 32'h0090_0000, 32'h7FFF_FFFF, 32'h1, 0, 4'b0),
                       1'b1, typed_result(32'h8000_0000, 1, 0, 0, 4'b1001)});
      for (int op = 0; op < 16; op++)
         rows.push_back('{make_request(KIND_DATA, {7'b0000000, 4'(op), 1'b1, 20'h00000},
                          32'h8000_0001, 32'hFFFF_FFFF, 0, 4'b0010), 1'b0, '0});
      // Shifter corners: immediate zero shifts and RRX, register amounts of 32 and beyond.
      for (int sh = 0; sh < 4; sh++) begin
         rows.push_back('{make_request(KIND_DATA, 32'h01B0_0000 | (sh << 5),
                          32'h0, 32'h8000_0001, 0, 4'b0010), 1'b0, '0});
         rows.push_back('{make_request(KIND_DATA, 32'h01B0_0010 | (sh << 5),
                          32'h0, 32'h8000_0001, 8'd32, 4'b0000), 1'b0, '0});
         rows.push_back('{make_request(KIND_DATA, 32'h01B0_0010 | (sh << 5),
                          32'h0, 32'h8000_0001, 8'd255, 4'b0000), 1'b0, '0});
      end
      rows.push_back('{make_request(KIND_DATA, 32'h03B0_02FF, 0, 0, 0, 4'b0010), 1'b0, '0});
      rows.push_back('{make_request(KIND_DATA, 32'h03B0_00FF, 0, 0, 0, 4'b0010), 1'b0, '0});

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) begin
         if (rows[i].typed) begin
            typed_want = execute_instruction(rows[i].req);
            if (typed_want !== rows[i].res)
               report_mismatch("directed row", 32'(i), 32'd0);
         end
         send_request(rows[i].req);
      end

      // Long receiver hold-off while requests keep coming, so the input stalls.
      fork
         begin
            hold_off = 1'b1;
            repeat (40) @(posedge clock);
            hold_off = 1'b0;
         end
         begin
            repeat (20) send_request(random_request());
            push <= 1'b0;
         end
      join

      for (int n = 0; n < NumRandom; n++) begin
         phase = (n * 5) / NumRandom;
         case (phase)
            0: begin sender_idle_pct = 0; receiver_stall_pct = 0; end
            1: begin sender_idle_pct = 58; receiver_stall_pct = 0; end
            2: begin sender_idle_pct = 0; receiver_stall_pct = 58; end
            3: begin sender_idle_pct = 32; receiver_stall_pct = 32; end
            default: begin sender_idle_pct = 0; receiver_stall_pct = 0; end
         endcase
         send_request(random_request());
      end
      push <= 1'b0;
      stimulus_done = 1'b1;

      while (expected_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (error_count == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

endmodule
